### sv/mma_pkg.sv
// Package with the payload types, sequencer states and fixed sizes of the moving average.
`default_nettype none

package mma_pkg;

    localparam int CHANNEL_COUNT = 6;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int CH_W          = $clog2(CHANNEL_COUNT);
    localparam int ROW_WIDTH     = CHANNEL_COUNT * SAMPLE_WIDTH;
    localparam int CFG_WIDTH     = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd16;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t [CHANNEL_COUNT-1:0]    chan_vec_t;

    typedef struct packed {
        logic [31:0] time_ms;
        sample_t     rate_x;
        sample_t     rate_y;
        sample_t     rate_z;
        sample_t     accel_x;
        sample_t     accel_y;
        sample_t     accel_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_time_ms;
        sample_t     out_rate_x;
        sample_t     out_rate_y;
        sample_t     out_rate_z;
        sample_t     out_accel_x;
        sample_t     out_accel_y;
        sample_t     out_accel_z;
        logic        averaged;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } seq_state_t;

    function automatic chan_vec_t in_channels(in_item_t d);
        chan_vec_t v;
        v[0] = d.rate_x;
        v[1] = d.rate_y;
        v[2] = d.rate_z;
        v[3] = d.accel_x;
        v[4] = d.accel_y;
        v[5] = d.accel_z;
        return v;
    endfunction

    function automatic out_item_t make_out(logic [31:0] t, chan_vec_t v, logic avg);
        out_item_t o;
        o.out_time_ms = t;
        o.out_rate_x  = v[0];
        o.out_rate_y  = v[1];
        o.out_rate_z  = v[2];
        o.out_accel_x = v[3];
        o.out_accel_y = v[4];
        o.out_accel_z = v[5];
        o.averaged    = avg;
        return o;
    endfunction

endpackage

`default_nettype wire

### sv/mma_history_ram.sv
// Sample history memory: one row of all channels per slot, registered read.
`default_nettype none

module mma_history_ram
    import mma_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_WIDTH-1:0] wr_addr,
    input  wire logic [ROW_WIDTH-1:0]  wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_WIDTH-1:0] rd_addr,
    output logic      [ROW_WIDTH-1:0]  rd_data
);

    logic [ROW_WIDTH-1:0] mem [DEPTH];
    logic [ROW_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/mma_divider.sv
// Radix-2 signed divider: truncating quotient of a running sum by the window length.
`default_nettype none

module mma_divider
    import mma_pkg::*;
#(
    parameter int SUM_W = 39,
    parameter int NW    = 7
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic        [NW-1:0]    divisor,
    output logic signed      [SUM_W-1:0] quotient,
    output div_status_t                  status
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [NW:0]      trial;
    logic             ge;

    // The dividend register shifts out its top bit while quotient bits shift in.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? NW'(trial - {1'b0, dvs_reg}) : trial[NW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign quotient    = neg_reg ? $signed(~quo_reg + 1'b1) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### sv/multichannel_moving_average.sv
// Top level of the multichannel boxcar moving average.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | in_data: timestamp and six Q16.16 channels
//  out     | out_valid/out_stall| out_data: timestamp, six channels, averaged
//  cfg     | cfg_write_en       | cfg_write_data: window length N (7 bits)
//
// A transaction passes through an accept step, one sum update step per channel and a
// done step; an averaged result adds per channel a divider start, SUM_W divider
// shift-subtract steps and a result capture.
// The radix-2 divider is shared by all channels.
// Reset and a window length write clear sums, fill count and write slot at once.
// A finished result waits in the output register while the next input is taken.
`default_nettype none

module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_WIDTH-1:0] cfg_write_data
);

    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int NW    = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_WIDTH + CW;

    seq_state_t state_reg, state_next;

    logic [CFG_WIDTH-1:0]    window_reg;
    logic [NW-1:0]           fill_reg;
    logic [AW-1:0]           slot_reg;
    logic signed [SUM_W-1:0] sum_reg [CHANNEL_COUNT];
    logic [CH_W-1:0]         ch_reg;
    logic                    full_reg;
    logic                    avg_reg;
    logic [AW-1:0]           cur_slot_reg;
    in_item_t                in_reg;
    chan_vec_t               res_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic [NW-1:0]           n_eff;
    logic [AW-1:0]           slot_eff;
    logic [NW-1:0]           slot_inc;
    logic [NW-1:0]           fill_next;
    logic [AW-1:0]           slot_next;
    logic                    avg_next;
    logic                    last_ch;
    logic                    accept;
    logic                    ld_out;
    logic                    rd_en;
    logic                    wr_en;
    logic                    upd_en;
    logic                    div_start;
    chan_vec_t               in_ch;
    chan_vec_t               old_ch;
    logic [ROW_WIDTH-1:0]    rd_row;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] sum_upd;
    logic signed [SUM_W-1:0] quotient;
    div_status_t             div_status;

    // A window length of zero acts as one; anything above the history depth is clamped.
    always_comb
    begin
        if (window_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(window_reg) > NW'(WINDOW_MAX))
        begin
            n_eff = NW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = NW'(window_reg);
        end
    end

    assign slot_eff  = (NW'(slot_reg) >= n_eff) ? '0 : slot_reg;
    assign slot_inc  = NW'(cur_slot_reg) + 1'b1;
    assign slot_next = (slot_inc >= n_eff) ? '0 : AW'(slot_inc);
    assign fill_next = full_reg ? fill_reg : fill_reg + 1'b1;
    assign avg_next  = (fill_next >= n_eff);
    assign last_ch   = (ch_reg == CH_W'(CHANNEL_COUNT - 1));
    assign accept    = in_valid && !in_stall;

    assign in_ch   = in_channels(in_reg);
    assign old_ch  = chan_vec_t'(rd_row);
    assign new_ext = SUM_W'(in_ch[ch_reg]);
    assign old_ext = full_reg ? SUM_W'(old_ch[ch_reg]) : '0;
    assign sum_upd = sum_reg[ch_reg] + new_ext - old_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (last_ch)
                begin
                    state_next = avg_next ? ST_DIV_START : ST_DONE;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = last_ch ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        upd_en    = 1'b0;
        div_start = 1'b0;
        ld_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_en    = in_valid;
            end
            ST_UPDATE:
            begin
                upd_en = 1'b1;
                // The old row was captured at accept, so the new row may overwrite it now.
                wr_en  = (ch_reg == '0);
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
            end
            ST_DONE:
            begin
                ld_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= CFG_RESET;
            fill_reg   <= '0;
            slot_reg   <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            window_reg <= cfg_write_data;
            fill_reg   <= '0;
            slot_reg   <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (upd_en)
        begin
            sum_reg[ch_reg] <= sum_upd;
            if (last_ch)
            begin
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else if (accept)
        begin
            ch_reg <= '0;
        end
        else if (upd_en || (div_status.done && state_reg == ST_DIV_WAIT))
        begin
            ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg       <= in_data;
            cur_slot_reg <= slot_eff;
            full_reg     <= (fill_reg >= n_eff);
        end
        if (upd_en && last_ch)
        begin
            avg_reg <= avg_next;
        end
        if (state_reg == ST_DIV_WAIT && div_status.done)
        begin
            res_reg[ch_reg] <= SAMPLE_WIDTH'(quotient);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_data_reg <= make_out(in_reg.time_ms, avg_reg ? res_reg : in_ch, avg_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    mma_history_ram #(
        .DEPTH      (WINDOW_MAX),
        .ADDR_WIDTH (AW)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_slot_reg),
        .wr_data (ROW_WIDTH'(in_ch)),
        .rd_en   (rd_en),
        .rd_addr (slot_eff),
        .rd_data (rd_row)
    );

    mma_divider #(
        .SUM_W (SUM_W),
        .NW    (NW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[ch_reg]),
        .divisor  (n_eff),
        .quotient (quotient),
        .status   (div_status)
    );

endmodule

`default_nettype wire
